// ===== rtl/core/hrhf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request header filter package
// Types, sizes and constants shared by the header filter logic.
// ----------------------------------------------------------------------------
package hrhf_pkg;

    // Store geometry
    localparam int BUF_DEPTH  = 512;
    localparam int FILL_W     = $clog2(BUF_DEPTH);
    localparam int PREFIX_LEN = 21;
    localparam int PFX_W      = $clog2(PREFIX_LEN + 1);

    // Item field widths
    localparam int FUNC_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int IDX_W     = 9;
    localparam int STATUS_W  = 2;
    localparam int LEN_W     = 9;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;

    // First character in the highest byte.
    localparam logic [8*PREFIX_LEN-1:0] AUTH_PREFIX = "Authorization: Basic ";

    typedef enum logic [FUNC_W-1:0] {
        FN_OPEN  = 3'd0,
        FN_DATA  = 3'd1,
        FN_EMPTY = 3'd2,
        FN_CLOSE = 3'd3,
        FN_READ  = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_REQLINE = 3'd1,
        PH_HEADERS = 3'd2,
        PH_BODY    = 3'd3,
        PH_DONE    = 3'd4,
        PH_DROPPED = 3'd5
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE    = 2'd0,
        ST_COLLECT = 2'd1,
        ST_DONE    = 2'd2,
        ST_DROPPED = 2'd3
    } status_t;

    // Character of the prefix at a line offset; zero past its end.
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [PFX_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        ch = '0;
        if (int'(pos) < PREFIX_LEN) begin
            ch = AUTH_PREFIX[8*(PREFIX_LEN-1-int'(pos)) +: 8];
        end
        return ch;
    endfunction

endpackage : hrhf_pkg
`default_nettype wire

// ===== rtl/core/http_request_header_filter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// HTTP request header filter
// Keeps the request line, "Authorization: Basic " header lines, the blank line
// and first body line of one connection in a byte store; reads bytes by index.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Content
//  s_*      | in        | tuser: func; tdata: data_byte, read_index
//  m_*      | out       | tdata: status, stored_length, read_byte, overflow_seen
//
//  One item per cycle while the output register is free or being emptied; each
//  result, read byte included, is registered and appears in the cycle after its item.
//  The store is written or read at most once per item, so a single port serves both.
//  Reset clears the control state only; the store contents are not cleared.
//  A stalled result holds in the output register; the input side keeps taking
//  items as long as that register is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module http_request_header_filter (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [7:0] data_byte, [16:8] read_index, [23:17] zero
    input  wire logic [hrhf_pkg::S_TDATA_W-1:0] s_tdata,
    // [2:0] func
    input  wire logic [hrhf_pkg::FUNC_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [1:0] status, [10:2] stored_length, [18:11] read_byte,
    // [19] overflow_seen, [23:20] zero
    output logic [hrhf_pkg::M_TDATA_W-1:0]      m_tdata
);
    import hrhf_pkg::*;

    // Byte store
    logic [BYTE_W-1:0] store_mem [BUF_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    // Control state
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [FILL_W-1:0] line_start_reg, line_start_next;
    phase_t            phase_reg, phase_next;
    logic              blank_reg, blank_next;
    logic [PFX_W-1:0]  progress_reg, progress_next;
    logic              failed_reg, failed_next;
    logic              ovf_reg, ovf_next;

    // Output register
    logic              out_valid_reg;
    status_t           status_reg, status_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              rd_hit_reg;
    logic              ovf_out_reg;

    // Input decode
    logic                     accept;
    func_t                    func;
    logic [BYTE_W-1:0]        in_byte;
    logic [IDX_W-1:0]         in_idx;
    logic [FILL_W+IDX_W-1:0]  idx_wide;
    logic                     idx_in_range;
    logic [FILL_W-1:0]        rd_addr;
    logic                     collecting;
    logic                     has_room;
    logic [FILL_W-1:0]        line_off;
    logic                     wr_en;
    logic                     rd_en;
    logic [FILL_W+LEN_W-1:0]  len_wide;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign func     = func_t'(s_tuser);
    assign in_byte  = s_tdata[BYTE_W-1:0];
    assign in_idx   = s_tdata[BYTE_W +: IDX_W];

    assign idx_wide     = {{FILL_W{1'b0}}, in_idx};
    assign idx_in_range = idx_wide < (FILL_W+IDX_W)'(BUF_DEPTH);
    assign rd_addr      = idx_wide[FILL_W-1:0];

    assign collecting = (phase_reg == PH_REQLINE) || (phase_reg == PH_HEADERS) ||
                        (phase_reg == PH_BODY);
    assign has_room   = fill_reg < FILL_W'(BUF_DEPTH - 1);
    assign line_off   = fill_reg - line_start_reg;

    assign wr_en = accept && (func == FN_DATA) && collecting && has_room;
    assign rd_en = accept && (func == FN_READ) && idx_in_range;

    // Next value of the parser state for the item at the input.
    always_comb begin
        fill_next       = fill_reg;
        line_start_next = line_start_reg;
        phase_next      = phase_reg;
        blank_next      = blank_reg;
        progress_next   = progress_reg;
        failed_next     = failed_reg;
        ovf_next        = ovf_reg;
        case (func)
            FN_OPEN: begin
                fill_next       = '0;
                line_start_next = '0;
                phase_next      = PH_REQLINE;
                blank_next      = 1'b1;
                progress_next   = '0;
                failed_next     = 1'b0;
                ovf_next        = 1'b0;
            end
            FN_DATA: begin
                if (collecting) begin
                    if (has_room) begin
                        // Incremental match of the prefix on stored header bytes.
                        if (phase_reg == PH_HEADERS && line_off < FILL_W'(PREFIX_LEN)) begin
                            if (!failed_reg &&
                                prefix_char(line_off[PFX_W-1:0]) == in_byte) begin
                                progress_next = progress_reg + PFX_W'(1);
                            end else begin
                                failed_next = 1'b1;
                            end
                        end
                        fill_next = fill_reg + FILL_W'(1);
                    end else begin
                        ovf_next = 1'b1;
                    end
                    if (in_byte == CHAR_LF) begin
                        case (phase_reg)
                            PH_REQLINE: begin
                                phase_next      = PH_HEADERS;
                                line_start_next = fill_next;
                            end
                            PH_HEADERS: begin
                                if (blank_reg) begin
                                    phase_next = PH_BODY;
                                end else if (!failed_next &&
                                             progress_next == PFX_W'(PREFIX_LEN)) begin
                                    line_start_next = fill_next;
                                end else begin
                                    // Drop the header line just seen.
                                    fill_next = line_start_reg;
                                end
                            end
                            PH_BODY: begin
                                line_start_next = fill_next;
                                phase_next = (fill_next != '0) ? PH_DONE : PH_DROPPED;
                            end
                            default: begin
                            end
                        endcase
                        blank_next    = 1'b1;
                        progress_next = '0;
                        failed_next   = 1'b0;
                    end else if (in_byte != CHAR_CR) begin
                        blank_next = 1'b0;
                    end
                end
            end
            FN_EMPTY: begin
                if (phase_reg == PH_BODY) begin
                    phase_next = (fill_reg != '0) ? PH_DONE : PH_DROPPED;
                end
            end
            FN_CLOSE: begin
                if (collecting) begin
                    phase_next = PH_DROPPED;
                end
            end
            default: begin
            end
        endcase
    end

    // Result fields for the item at the input.
    always_comb begin
        case (phase_next)
            PH_IDLE:    status_next = ST_NONE;
            PH_DONE:    status_next = ST_DONE;
            PH_DROPPED: status_next = ST_DROPPED;
            default:    status_next = ST_COLLECT;
        endcase
        len_wide = {{LEN_W{1'b0}}, fill_next};
        len_next = len_wide[LEN_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            line_start_reg <= '0;
            phase_reg      <= PH_IDLE;
            blank_reg      <= 1'b1;
            progress_reg   <= '0;
            failed_reg     <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg       <= fill_next;
                line_start_reg <= line_start_next;
                phase_reg      <= phase_next;
                blank_reg      <= blank_next;
                progress_reg   <= progress_next;
                failed_reg     <= failed_next;
                ovf_reg        <= ovf_next;
                out_valid_reg  <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            len_reg     <= len_next;
            rd_hit_reg  <= rd_en;
            ovf_out_reg <= ovf_next;
        end
    end

    // Single-port store: at most one write or one registered read per item.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[fill_reg] <= in_byte;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-STATUS_W-LEN_W-BYTE_W-1){1'b0}},
                       ovf_out_reg,
                       rd_hit_reg ? rd_data_reg : {BYTE_W{1'b0}},
                       len_reg,
                       status_reg};

`ifndef SYNTHESIS
    a_line_start_le_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        line_start_reg <= fill_reg)
        else $error("line start beyond fill point");

    a_progress_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        progress_reg <= PFX_W'(PREFIX_LEN))
        else $error("prefix progress beyond prefix length");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> out_valid_reg)
        else $error("accepted item produced no result");

    a_ovf_rise_on_data: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(ovf_reg) |-> $past(accept && func == FN_DATA))
        else $error("overflow flag set without a data item");

    a_done_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && phase_next == PH_DONE) |-> (fill_next != '0))
        else $error("request complete with empty store");
`endif

endmodule : http_request_header_filter
`default_nettype wire
